FILE: hdl/lsas_pkg.sv
// lsas_pkg: shared constants, micro-op and jump codes, control word type and
// the microcode program of the low speed angle stepper.
// no dependencies; imported by the sequencer, the datapath and the top level.
`timescale 1ns / 1ps

package lsas_pkg;

    // stream payload widths
    localparam int InDataW  = 48;
    localparam int OutDataW = 32;

    // field widths
    localparam int SpeedW  = 14;
    localparam int MagW    = 13;
    localparam int TickW   = 32;
    localparam int AngleW  = 10;
    localparam int PeriodW = 11;
    localparam int StepW   = 4;
    localparam int NumW    = 14;
    localparam int DivW    = 16;
    localparam int CntW    = 4;
    localparam int KW      = 3;
    localparam int PcW     = 3;

    // arithmetic constants
    localparam logic [MagW-1:0] SpeedMax   = 13'd8191;
    localparam logic [MagW-1:0] SmallSpeed = 13'd27;
    localparam logic [NumW-1:0] TickNum    = 14'd1875;
    localparam logic [CntW-1:0] DivLastBit = 4'd10;

    // micro-ops
    localparam logic [2:0] UOP_NOP      = 3'd0;
    localparam logic [2:0] UOP_LOAD     = 3'd1;
    localparam logic [2:0] UOP_DIV_INIT = 3'd2;
    localparam logic [2:0] UOP_DIV_STEP = 3'd3;
    localparam logic [2:0] UOP_EVAL     = 3'd4;
    localparam logic [2:0] UOP_NEXT     = 3'd5;
    localparam logic [2:0] UOP_FINISH   = 3'd6;

    // jump conditions: jump to target when true, else fall through
    localparam logic [2:0] JC_NONE     = 3'd0;
    localparam logic [2:0] JC_ALWAYS   = 3'd1;
    localparam logic [2:0] JC_NO_IN    = 3'd2;
    localparam logic [2:0] JC_ZERO     = 3'd3;
    localparam logic [2:0] JC_CNT_NZ   = 3'd4;
    localparam logic [2:0] JC_MORE     = 3'd5;
    localparam logic [2:0] JC_OUT_BUSY = 3'd6;

    // program addresses
    localparam logic [PcW-1:0] PC_LOAD   = 3'd0;
    localparam logic [PcW-1:0] PC_INIT   = 3'd1;
    localparam logic [PcW-1:0] PC_DIV    = 3'd2;
    localparam logic [PcW-1:0] PC_EVAL   = 3'd3;
    localparam logic [PcW-1:0] PC_NEXT   = 3'd4;
    localparam logic [PcW-1:0] PC_FINISH = 3'd5;
    localparam logic [PcW-1:0] PC_RET    = 3'd6;

    typedef struct packed {
        logic [2:0]     op;
        logic [2:0]     cond;
        logic [PcW-1:0] target;
    } t_uword;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic s_zero;
        logic cnt_nz;
        logic more;
        logic out_busy;
    } t_status;

    // microcode program
    function automatic t_uword lsas_ucode(input logic [PcW-1:0] pc);
        t_uword w;
        case (pc)
            PC_LOAD:   w = '{op: UOP_LOAD,     cond: JC_NO_IN,    target: PC_LOAD};
            PC_INIT:   w = '{op: UOP_DIV_INIT, cond: JC_ZERO,     target: PC_FINISH};
            PC_DIV:    w = '{op: UOP_DIV_STEP, cond: JC_CNT_NZ,   target: PC_DIV};
            PC_EVAL:   w = '{op: UOP_EVAL,     cond: JC_NONE,     target: PC_LOAD};
            PC_NEXT:   w = '{op: UOP_NEXT,     cond: JC_MORE,     target: PC_INIT};
            PC_FINISH: w = '{op: UOP_FINISH,   cond: JC_OUT_BUSY, target: PC_FINISH};
            PC_RET:    w = '{op: UOP_NOP,      cond: JC_ALWAYS,   target: PC_LOAD};
            default:   w = '{op: UOP_NOP,      cond: JC_ALWAYS,   target: PC_LOAD};
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/lsas_sequencer.sv
// lsas_sequencer: step counter over the microcode table with conditional jumps.
// depends on lsas_pkg for the program and the code constants.
`timescale 1ns / 1ps

module lsas_sequencer
    import lsas_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_status    i_status,
    output logic [2:0] o_op
);

    logic [PcW-1:0] r_pc;
    logic [PcW-1:0] n_pc;
    t_uword         w_uw;
    logic           w_jump;

    assign w_uw = lsas_ucode(r_pc);
    assign o_op = w_uw.op;

    // jump condition select
    always_comb begin
        case (w_uw.cond)
            JC_NONE:     w_jump = 1'b0;
            JC_ALWAYS:   w_jump = 1'b1;
            JC_NO_IN:    w_jump = !i_status.in_valid;
            JC_ZERO:     w_jump = i_status.s_zero;
            JC_CNT_NZ:   w_jump = i_status.cnt_nz;
            JC_MORE:     w_jump = i_status.more;
            JC_OUT_BUSY: w_jump = i_status.out_busy;
            default:     w_jump = 1'b1;
        endcase
        n_pc = w_jump ? w_uw.target : r_pc + 1'b1;
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_LOAD;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

FILE: hdl/lsas_datapath.sv
// lsas_datapath: speed magnitude, shift-subtract divider, candidate compare,
// angle and tick state, and the output register.
// depends on lsas_pkg; driven by micro-ops from lsas_sequencer.
`timescale 1ns / 1ps

module lsas_datapath
    import lsas_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [2:0]          i_op,
    output t_status             o_status,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [InDataW-1:0]  i_s_tdata,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [OutDataW-1:0] o_m_tdata
);

    // working registers
    logic [MagW-1:0]    r_s;
    logic               r_neg;
    logic [TickW-1:0]   r_tick;
    logic [KW-1:0]      r_k;
    logic [KW-1:0]      r_top;
    logic [NumW-1:0]    r_num;
    logic [NumW-1:0]    r_rem;
    logic [PeriodW-1:0] r_q;
    logic [CntW-1:0]    r_cnt;
    logic [DivW-1:0]    r_best;
    logic [PeriodW-1:0] r_t;
    logic [KW-1:0]      r_n;

    // block state
    logic [AngleW-1:0]  r_angle;
    logic [TickW-1:0]   r_last;

    // output register
    logic               r_out_valid;
    logic [AngleW-1:0]  r_out_angle;
    logic [PeriodW-1:0] r_out_t;
    logic [StepW-1:0]   r_out_step;
    logic               r_out_stepped;

    logic [SpeedW-1:0]  w_raw;
    logic [SpeedW-1:0]  w_mag14;
    logic [MagW-1:0]    w_mag;
    logic [DivW-1:0]    w_d;
    logic [DivW-2:0]    w_four_s;
    logic [26:0]        w_dsh;
    logic               w_fits;
    logic [DivW-1:0]    w_rem16;
    logic               w_fold;
    logic [DivW-1:0]    w_err;
    logic               w_better;
    logic [TickW-1:0]   w_diff;
    logic               w_stepped;
    logic [StepW-1:0]   w_step;
    logic [AngleW-1:0]  w_angle_new;
    logic               w_out_busy;
    logic               w_load;
    logic               w_finish;

    // input magnitude, most negative code saturates
    assign w_raw   = i_s_tdata[SpeedW-1:0];
    assign w_mag14 = w_raw[SpeedW-1] ? (~w_raw + 1'b1) : w_raw;
    assign w_mag   = (w_mag14 > {1'b0, SpeedMax}) ? SpeedMax : w_mag14[MagW-1:0];

    // divisor 8s and half point 4s
    assign w_d      = {r_s, 3'b000};
    assign w_four_s = {r_s, 2'b00};

    // one quotient bit per step
    assign w_dsh  = {11'd0, w_d} << r_cnt;
    assign w_fits = {13'd0, r_rem} >= w_dsh;

    // rounding error of this candidate, ties keep the earlier one
    assign w_rem16  = {2'b00, r_rem};
    assign w_fold   = w_rem16 > {1'b0, w_four_s};
    assign w_err    = w_fold ? (w_d - w_rem16) : w_rem16;
    assign w_better = w_err < r_best;

    // step event
    assign w_diff      = r_tick - r_last;
    assign w_stepped   = w_diff >= {{(TickW-PeriodW){1'b0}}, r_t};
    assign w_step      = r_neg ? (~{1'b0, r_n} + 1'b1) : {1'b0, r_n};
    assign w_angle_new = r_angle + {{(AngleW-StepW){w_step[StepW-1]}}, w_step};

    assign w_out_busy = r_out_valid && !i_m_tready;
    assign w_load     = (i_op == UOP_LOAD) && i_s_tvalid;
    assign w_finish   = (i_op == UOP_FINISH) && !w_out_busy;

    assign o_s_tready = (i_op == UOP_LOAD);

    assign o_status.in_valid = i_s_tvalid;
    assign o_status.s_zero   = (r_s == '0);
    assign o_status.cnt_nz   = (r_cnt != '0);
    assign o_status.more     = (r_k < r_top);
    assign o_status.out_busy = w_out_busy;

    // search datapath, no reset needed
    always_ff @(posedge i_clk) begin
        case (i_op)
            UOP_LOAD: begin
                if (w_load) begin
                    r_s    <= w_mag;
                    r_neg  <= w_raw[SpeedW-1];
                    r_tick <= i_s_tdata[SpeedW +: TickW];
                    r_k    <= KW'(1);
                    r_top  <= (w_mag <= SmallSpeed) ? KW'(3) : KW'(5);
                    r_num  <= TickNum;
                    r_best <= '1;
                    r_t    <= PeriodW'(1);
                    r_n    <= '0;
                end
            end
            UOP_DIV_INIT: begin
                r_rem <= r_num;
                r_q   <= '0;
                r_cnt <= DivLastBit;
            end
            UOP_DIV_STEP: begin
                if (w_fits) begin
                    r_rem <= r_rem - w_dsh[NumW-1:0];
                end
                r_q   <= {r_q[PeriodW-2:0], w_fits};
                r_cnt <= r_cnt - 1'b1;
            end
            UOP_EVAL: begin
                if (w_better) begin
                    r_best <= w_err;
                    r_t    <= r_q + {{(PeriodW-1){1'b0}}, w_fold};
                    r_n    <= r_k;
                end
            end
            UOP_NEXT: begin
                r_k   <= r_k + 1'b1;
                r_num <= r_num + TickNum;
            end
            default: begin
            end
        endcase
    end

    // angle and last step tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
            r_last  <= '0;
        end else if (w_finish && w_stepped) begin
            r_angle <= w_angle_new;
            r_last  <= r_tick;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_angle   <= w_stepped ? w_angle_new : r_angle;
            r_out_t       <= r_t;
            r_out_step    <= w_step;
            r_out_stepped <= w_stepped;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_stepped, r_out_step, r_out_t, r_out_angle};

endmodule

FILE: hdl/low_speed_angle_stepper.sv
// low_speed_angle_stepper: top level, microcode sequencer plus datapath.
// one beat is in work at a time; the search runs the 11-step shift-subtract divider
// once per candidate, and is skipped at zero speed.
// the output register holds one result, so the next beat is taken while it waits.
// reset (i_rst_n low, synchronous) clears angle, last step tick and output valid.
`timescale 1ns / 1ps

module low_speed_angle_stepper
    import lsas_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // [13:0] speed, [45:14] tick_count
    input  logic [InDataW-1:0]  i_s_tdata,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // [9:0] angle, [20:10] step_period, [24:21] step_size, [25] stepped
    output logic [OutDataW-1:0] o_m_tdata
);

    logic [2:0] w_op;
    t_status    w_status;

    // control program
    lsas_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_op     (w_op)
    );

    // arithmetic and state
    lsas_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_op),
        .o_status   (w_status),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

FILE: hdl/lsas_checker.sv
// lsas_checker: port-level assertions for low_speed_angle_stepper, with bind.
// depends on lsas_pkg for widths.
`timescale 1ns / 1ps

module lsas_checker
    import lsas_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_tvalid,
    input logic                o_s_tready,
    input logic [InDataW-1:0]  i_s_tdata,
    input logic                o_m_tvalid,
    input logic                i_m_tready,
    input logic [OutDataW-1:0] o_m_tdata
);

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // one item at a time: no second beat right after an accepted one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while busy");

    // step size stays within five counts
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[24:21] == 4'd6 || o_m_tdata[24:21] == 4'd7 ||
                         o_m_tdata[24:21] == 4'd8 || o_m_tdata[24:21] == 4'd9 ||
                         o_m_tdata[24:21] == 4'd10))
        else $error("step size out of range");

    // period never above the slowest rounding
    a_period_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[20:10] <= 11'd1172)
        else $error("step period out of range");

endmodule

bind low_speed_angle_stepper lsas_checker u_lsas_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

FILE: sim/tb.sv
// tb: self-checking bench for low_speed_angle_stepper; streams speed and tick beats,
// predicts angle, step period, step size and step flag per beat, and checks each result.
// depends on lsas_pkg and the low_speed_angle_stepper rtl.
`timescale 1ns / 1ps

module tb;
    import lsas_pkg::*;

    localparam int TickBeats   = 1850;
    localparam int StallLimit  = 2000;
    localparam int DrainCycles = 120;

    typedef struct packed {
        logic [AngleW-1:0]       angle;
        logic [PeriodW-1:0]      period;
        logic signed [StepW-1:0] step_size;
        logic                    stepped;
    } t_angle_result;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    // [13:0] speed, [45:14] tick_count
    logic [InDataW-1:0]  i_s_tdata  = '0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    // [9:0] angle, [20:10] step_period, [24:21] step_size, [25] stepped
    logic [OutDataW-1:0] o_m_tdata;

    // beats waiting to be sent and results waiting to come back
    logic [InDataW-1:0] tick_beats_q[$];
    t_angle_result      angle_results_q[$];

    // predicted block state
    logic [AngleW-1:0] angle_q     = '0;
    logic [TickW-1:0]  last_step_q = '0;

    int unsigned tx_gap     = 0;
    int unsigned rx_hold    = 0;
    bit          tx_idle    = 1'b1;
    bit          rx_idle    = 1'b1;
    int unsigned n_fail     = 0;
    int unsigned quiet_cnt  = 0;

    low_speed_angle_stepper dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [InDataW-1:0] tick_beat(input int speed,
                                                     input logic [TickW-1:0] tick);
        logic [SpeedW-1:0] raw;
        raw = speed[SpeedW-1:0];
        return {{(InDataW-SpeedW-TickW){1'b0}}, tick, raw};
    endfunction

    // work out the step choice for one tick and advance the predicted angle
    function automatic t_angle_result advance_angle(input logic [InDataW-1:0] beat);
        logic [SpeedW-1:0] raw;
        logic [SpeedW-1:0] mag;
        logic [TickW-1:0]  tick;
        logic [2:0]        size;
        int unsigned       best;
        int unsigned       num;
        int unsigned       rem;
        int unsigned       div;
        int unsigned       top;
        int unsigned       up;
        int unsigned       k;
        t_angle_result     res;
        raw  = beat[SpeedW-1:0];
        tick = beat[SpeedW +: TickW];
        res  = '0;
        res.period = PeriodW'(1);
        size = '0;
        if (raw != '0) begin
            mag = raw[SpeedW-1] ? (~raw + 1'b1) : raw;
            // most negative speed saturates
            if (mag > {1'b0, SpeedMax})
                mag = {1'b0, SpeedMax};
            best = 32'hFFFF_FFFF;
            div  = 8 * mag;
            top  = (mag <= SmallSpeed) ? 3 : 5;
            // round 1875*k/(8*s) to nearest, half down, keep first smallest error
            for (k = 1; k <= top; k++) begin
                num = TickNum * k;
                rem = num % div;
                up  = 0;
                if (rem > 4 * mag) begin
                    rem = div - rem;
                    up  = 1;
                end
                if (rem < best) begin
                    best       = rem;
                    res.period = PeriodW'(num / div + up);
                    size       = 3'(k);
                end
            end
            res.step_size = raw[SpeedW-1] ? -$signed({1'b0, size}) : $signed({1'b0, size});
        end
        // wrapping tick difference decides the step
        if (tick - last_step_q >= res.period) begin
            angle_q     = angle_q + {{(AngleW-StepW){res.step_size[StepW-1]}}, res.step_size};
            last_step_q = tick;
            res.stepped = 1'b1;
        end
        res.angle = angle_q;
        return res;
    endfunction

    // sender: feeds beats from the queue with random gaps
    always @(posedge i_clk) begin
        logic        vld;
        int unsigned gap;
        vld = i_s_tvalid;
        gap = tx_gap;
        if (!i_rst_n) begin
            vld = 1'b0;
            gap = 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                angle_results_q.push_back(advance_angle(i_s_tdata));
                vld = 1'b0;
                if ($urandom_range(0, 63) == 0)
                    tx_idle = !tx_idle;
                gap = tx_idle ? $urandom_range(0, 15) : 0;
            end
            if (!vld) begin
                if (gap != 0) begin
                    gap = gap - 1;
                end else if (tick_beats_q.size() != 0) begin
                    vld = 1'b1;
                    i_s_tdata <= tick_beats_q.pop_front();
                end
            end
        end
        i_s_tvalid <= vld;
        tx_gap     <= gap;
    end

    // receiver: random stalls, compares each result beat with the oldest prediction
    always @(posedge i_clk) begin
        int unsigned   hold;
        t_angle_result want;
        t_angle_result got;
        hold = rx_hold;
        if (!i_rst_n) begin
            hold = 1;
        end else if (o_m_tvalid && i_m_tready) begin
            got = '{angle:     o_m_tdata[9:0],
                    period:    o_m_tdata[20:10],
                    step_size: o_m_tdata[24:21],
                    stepped:   o_m_tdata[25]};
            if (angle_results_q.size() == 0) begin
                $error("result beat with no prediction pending: %h", o_m_tdata);
                n_fail++;
            end else begin
                want = angle_results_q.pop_front();
                if (got.angle !== want.angle) begin
                    $error("angle: expected %0d, actual %0d", want.angle, got.angle);
                    n_fail++;
                end
                if (got.period !== want.period) begin
                    $error("step_period: expected %0d, actual %0d", want.period, got.period);
                    n_fail++;
                end
                if (got.step_size !== want.step_size) begin
                    $error("step_size: expected %0d, actual %0d",
                           want.step_size, got.step_size);
                    n_fail++;
                end
                if (got.stepped !== want.stepped) begin
                    $error("stepped: expected %0d, actual %0d", want.stepped, got.stepped);
                    n_fail++;
                end
            end
            if ($urandom_range(0, 63) == 0)
                rx_idle = !rx_idle;
            hold = rx_idle ? $urandom_range(0, 15) : 0;
        end else if (hold != 0) begin
            hold = hold - 1;
        end
        rx_hold    <= hold;
        i_m_tready <= (hold == 0) && i_rst_n;
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= StallLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [TickW-1:0] tick;
        int               speed;
        int               seg_len;
        int               pace_kind;
        int unsigned      tick_lim;
        int               i;

        // directed: zero speed, both speed ends, saturation, zero period, tick wrap
        tick_beats_q.push_back(tick_beat(0, 32'd0));
        tick_beats_q.push_back(tick_beat(0, 32'd1));
        tick_beats_q.push_back(tick_beat(1, 32'd2));
        tick_beats_q.push_back(tick_beat(1, 32'd705));
        tick_beats_q.push_back(tick_beat(-1, 32'd1408));
        tick_beats_q.push_back(tick_beat(-1, 32'd1409));
        tick_beats_q.push_back(tick_beat(27, 32'd1500));
        tick_beats_q.push_back(tick_beat(-27, 32'd1600));
        tick_beats_q.push_back(tick_beat(28, 32'd1700));
        tick_beats_q.push_back(tick_beat(-28, 32'd1800));
        tick_beats_q.push_back(tick_beat(8191, 32'd1800));
        tick_beats_q.push_back(tick_beat(8191, 32'd1800));
        tick_beats_q.push_back(tick_beat(-8191, 32'd1801));
        tick_beats_q.push_back(tick_beat(-8192, 32'd1802));
        tick_beats_q.push_back(tick_beat(-8192, 32'd1802));
        tick_beats_q.push_back(tick_beat(8191, 32'hFFFF_FFFF));
        tick_beats_q.push_back(tick_beat(100, 32'h0000_0000));
        tick_beats_q.push_back(tick_beat(0, 32'h0000_0000));
        tick_beats_q.push_back(tick_beat(0, 32'hFFFF_FFFE));
        tick_beats_q.push_back(tick_beat(-300, 32'h8000_0000));
        tick_beats_q.push_back(tick_beat(-300, 32'h0000_0005));
        tick_beats_q.push_back(tick_beat(5000, 32'h5555_5555));
        tick_beats_q.push_back(tick_beat(-5000, 32'hAAAA_AAAA));

        // random: runs of steady speed with advancing ticks, some noise
        tick = $urandom();
        while (tick_beats_q.size() < TickBeats + 23) begin
            seg_len   = $urandom_range(10, 60);
            pace_kind = $urandom_range(0, 9);
            case ($urandom_range(0, 4))
                0:       tick_lim = 1;
                1:       tick_lim = 4;
                2:       tick_lim = 32;
                3:       tick_lim = 256;
                default: tick_lim = 2048;
            endcase
            if ($urandom_range(0, 7) == 0)
                tick = $urandom();
            case (pace_kind)
                0:       speed = 0;
                1, 2, 3: speed = $urandom_range(1, 27);
                4, 5, 6: speed = $urandom_range(28, 600);
                7:       speed = $urandom_range(601, 8191);
                8:       speed = ($urandom_range(0, 1) == 0) ? 8191 : 8192;
                default: speed = $urandom_range(0, 16383);
            endcase
            if (pace_kind != 9 && $urandom_range(0, 1) == 0)
                speed = -speed;
            for (i = 0; i < seg_len; i++) begin
                if (pace_kind == 9 || $urandom_range(0, 19) == 0) begin
                    tick_beats_q.push_back(tick_beat($urandom_range(0, 16383), $urandom()));
                end else begin
                    tick = tick + $urandom_range(0, tick_lim);
                    tick_beats_q.push_back(tick_beat(speed, tick));
                end
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for all beats out and all results back
        while (tick_beats_q.size() != 0 || i_s_tvalid || angle_results_q.size() != 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (n_fail == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
hdl/lsas_pkg.sv
hdl/lsas_sequencer.sv
hdl/lsas_datapath.sv
hdl/low_speed_angle_stepper.sv
hdl/lsas_checker.sv
sim/tb.sv
